// ===== hdl/dmb_pkg.sv =====
// dmb_pkg: shared types and codes for the density matrix build block
// no dependencies; used by every module of the block
`default_nettype none

package dmb_pkg;

  localparam int unsigned CountW = 7;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned DensW  = 39;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic REG_BASIS_COUNT    = 1'b0;
  localparam logic REG_OCCUPIED_COUNT = 1'b1;

  localparam logic [CountW-1:0] BASIS_COUNT_RST    = 7'd64;
  localparam logic [CountW-1:0] OCCUPIED_COUNT_RST = 7'd1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_RANGE
  } cmd_kind_e;

  typedef struct packed {
    logic                    opcode;
    logic        [IdxW-1:0]  orbital;
    logic        [IdxW-1:0]  row;
    logic        [IdxW-1:0]  column;
    logic signed [CoefW-1:0] coefficient;
  } in_item_t;

  typedef struct packed {
    logic signed [DensW-1:0] density;
    logic                    range_error;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e                kind;
    logic        [IdxW-1:0]   orbital;
    logic        [IdxW-1:0]   row;
    logic        [IdxW-1:0]   column;
    logic signed [CoefW-1:0]  coefficient;
    logic        [CountW-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } q_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/dmb_front.sv =====
// dmb_front: configuration registers and classification of incoming transactions
// depends on dmb_pkg; feeds dmb_fifo
`default_nettype none

module dmb_front import dmb_pkg::*; #(
  parameter int unsigned MAX_BASIS    = 64,
  parameter int unsigned MAX_OCCUPIED = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CountW-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output cmd_t                   q_cmd_o
);

  logic [CountW-1:0] basis_q, basis_d;
  logic [CountW-1:0] occ_q, occ_d;
  logic [CountW-1:0] nb, no;
  logic              row_ok, col_ok, orb_ok, accept;

  always_comb begin
    basis_d = basis_q;
    occ_d   = occ_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASIS_COUNT:    basis_d = cfg_data_i;
        REG_OCCUPIED_COUNT: occ_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q <= BASIS_COUNT_RST;
      occ_q   <= OCCUPIED_COUNT_RST;
    end else begin
      basis_q <= basis_d;
      occ_q   <= occ_d;
    end
  end

  assign nb = (32'(basis_q) > MAX_BASIS) ? CountW'(MAX_BASIS) : basis_q;
  assign no = (32'(occ_q) > MAX_OCCUPIED) ? CountW'(MAX_OCCUPIED) : occ_q;

  assign row_ok = CountW'(in_data_i.row) < nb;
  assign col_ok = CountW'(in_data_i.column) < nb;
  assign orb_ok = 32'(in_data_i.orbital) < MAX_OCCUPIED;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    q_cmd_o.orbital     = in_data_i.orbital;
    q_cmd_o.row         = in_data_i.row;
    q_cmd_o.column      = in_data_i.column;
    q_cmd_o.coefficient = in_data_i.coefficient;
    q_cmd_o.count       = no;
    q_cmd_o.kind        = CMD_WRITE;
    q_push_o            = 1'b0;
    case (in_data_i.opcode)
      OP_WRITE: begin
        q_cmd_o.kind = CMD_WRITE;
        q_push_o     = accept && row_ok && orb_ok;
      end
      OP_READ: begin
        q_cmd_o.kind = (row_ok && col_ok) ? CMD_READ : CMD_RANGE;
        q_push_o     = accept;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dmb_fifo.sv =====
// dmb_fifo: two-entry command queue between the front and the back
// depends on dmb_pkg
`default_nettype none

module dmb_fifo import dmb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output q_ctrl_t   ctrl_o
);

  localparam int unsigned Depth = 2;

  cmd_t       entry_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       full, empty;

  assign full   = cnt_q == 2'(Depth);
  assign empty  = cnt_q == 2'd0;
  assign head_o = entry_q[rd_ptr_q];

  assign ctrl_o.push  = push_i;
  assign ctrl_o.full  = full;
  assign ctrl_o.pop   = pop_i;
  assign ctrl_o.empty = empty;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !pop_i) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("queue count overflow");
`endif

endmodule

`default_nettype wire

// ===== hdl/dmb_back.sv =====
// dmb_back: coefficient store, multiply-accumulate pipeline and result register
// depends on dmb_pkg; drains commands from dmb_fifo
`default_nettype none

module dmb_back import dmb_pkg::*; #(
  parameter int unsigned MAX_BASIS    = 64,
  parameter int unsigned MAX_OCCUPIED = 64
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cmd_t    head_i,
  input  wire q_ctrl_t q_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_item_t    out_data_o
);

  localparam int unsigned BW       = $clog2(MAX_BASIS);
  localparam int unsigned OW       = (MAX_OCCUPIED > 1) ? $clog2(MAX_OCCUPIED) : 1;
  localparam int unsigned AW       = OW + BW;
  localparam int unsigned MemDepth = MAX_OCCUPIED * (2 ** BW);
  localparam int unsigned AccW     = DensW - 1;
  localparam int unsigned ProdW    = 2 * CoefW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic signed [CoefW-1:0] mem [MemDepth];

  logic [1:0]              state_q, state_d;
  logic [CountW-1:0]       k_q, k_d;
  logic [CountW-1:0]       cnt_q, cnt_d;
  logic [IdxW-1:0]         row_q, row_d;
  logic [IdxW-1:0]         col_q, col_d;
  logic                    rerr_q, rerr_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [CoefW-1:0] rd_a_q, rd_b_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    v1_q, v1_d, last1_q, last1_d;
  logic                    v2_q, last2_q;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;
  logic                    mem_we, issue, last_issue, emit;
  logic [AW-1:0]           wr_addr, rd_addr_a, rd_addr_b;

  assign pop_o      = (state_q == ST_IDLE) && !q_i.empty;
  assign mem_we     = pop_o && (head_i.kind == CMD_WRITE);
  assign wr_addr    = {OW'(head_i.orbital), BW'(head_i.row)};
  assign issue      = state_q == ST_ISSUE;
  assign last_issue = (k_q + CountW'(1)) == cnt_q;
  assign rd_addr_a  = {OW'(k_q), BW'(row_q)};
  assign rd_addr_b  = {OW'(k_q), BW'(col_q)};
  assign emit       = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    col_d   = col_q;
    rerr_d  = rerr_q;
    acc_d   = v2_q ? acc_q + AccW'(prod_q) : acc_q;
    v1_d    = 1'b0;
    last1_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          row_d  = head_i.row;
          col_d  = head_i.column;
          cnt_d  = head_i.count;
          k_d    = '0;
          acc_d  = '0;
          rerr_d = 1'b0;
          case (head_i.kind)
            CMD_WRITE: state_d = ST_IDLE;
            CMD_READ:  state_d = (head_i.count == '0) ? ST_EMIT : ST_ISSUE;
            CMD_RANGE: begin
              rerr_d  = 1'b1;
              state_d = ST_EMIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ISSUE: begin
        v1_d    = 1'b1;
        last1_d = last_issue;
        k_d     = k_q + CountW'(1);
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v2_q && last2_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d       = 1'b1;
      out_d.density     = {acc_q, 1'b0};
      out_d.range_error = rerr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v1_q        <= 1'b0;
      last1_q     <= 1'b0;
      v2_q        <= 1'b0;
      last2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      v1_q        <= v1_d;
      last1_q     <= last1_d;
      v2_q        <= v1_q;
      last2_q     <= last1_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    cnt_q  <= cnt_d;
    row_q  <= row_d;
    col_q  <= col_d;
    rerr_q <= rerr_d;
    acc_q  <= acc_d;
    prod_q <= rd_a_q * rd_b_q;
    out_q  <= out_d;
  end

  // coefficient store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= head_i.coefficient;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_a_q <= mem[rd_addr_a];
      rd_b_q <= mem[rd_addr_b];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last2_q |-> v2_q) else $error("last flag without valid product");
  a_issue_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ISSUE |-> k_q < cnt_q) else $error("issue beyond occupied count");
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |-> out_data_o.density == '0)
    else $error("range error with nonzero density");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || v2_q) |-> !pop_o) else $error("pop while pipeline busy");
`endif

endmodule

`default_nettype wire

// ===== hdl/density_matrix_build.sv =====
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_ready_o    in_data_i  (in_item_t)
// out       out  out_valid_o / out_ready_i  out_data_o (out_item_t)
// cfg       in   cfg_we_i                   cfg_idx_i, cfg_data_i
//
// a read runs in the back end through the single multiply-accumulate pipeline
// (store read, multiply, accumulate) over orbitals; a write is stored as it is
// popped; an out-of-range read goes straight to the result register; the front
// keeps accepting into a two-entry queue, until full, while the back end or the
// result register stalls; rst_ni clears control state, the store is not cleared
`default_nettype none

module density_matrix_build import dmb_pkg::*; #(
  parameter int unsigned MAX_BASIS    = 64,
  parameter int unsigned MAX_OCCUPIED = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CountW-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o
);

  cmd_t    push_cmd, head;
  logic    push, pop;
  q_ctrl_t q_ctrl;

  dmb_front #(
    .MAX_BASIS    (MAX_BASIS),
    .MAX_OCCUPIED (MAX_OCCUPIED)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_ctrl.full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  dmb_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .ctrl_o     (q_ctrl)
  );

  dmb_back #(
    .MAX_BASIS    (MAX_BASIS),
    .MAX_OCCUPIED (MAX_OCCUPIED)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_i         (q_ctrl),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
